>>> hw/rtl/abrb_pkg.sv
// Shared types, constants and helpers for the atomic byte ring buffer.
// No dependencies; every other file of the block imports this package.
package abrb_pkg;

    // Store geometry and field widths
    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int RING_W    = $clog2(DEPTH + 1);
    localparam int MAX_XFER  = 64;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int USED_W    = 10;
    localparam int SIZE_W    = 11;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_SIZE_IN_USE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_PEEK    = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    // Back end states
    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } back_state_t;

    // One queued job: a single status beat, or a byte burst from the store
    typedef struct packed {
        logic              burst;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic              accepted;
        logic [LEN_W-1:0]  count;
        logic [USED_W-1:0] used;
        logic [USED_W-1:0] free;
    } job_t;

    // Store write request from the front
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    // (pos + inc) mod ring, valid while pos < ring and inc <= ring
    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0] pos,
        input logic [RING_W-1:0] inc,
        input logic [RING_W-1:0] ring
    );
        logic [RING_W:0] sum;
        sum = (RING_W+1)'(pos) + (RING_W+1)'(inc);
        if (sum >= (RING_W+1)'(ring))
        begin
            sum = sum - (RING_W+1)'(ring);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

>>> hw/rtl/abrb_front.sv
// Front end: accepts items, tracks ring positions and write runs, decides
// accept/refuse and queues result jobs. Depends on abrb_pkg.
module abrb_front
    import abrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_clear,
    input  logic [RING_W-1:0] ring_len,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  logic [LEN_W-1:0]  length,
    input  logic              first,
    input  logic [BYTE_W-1:0] data,
    input  logic              q_full,
    input  logic              burst_done,
    output logic              busy,
    output logic              enq,
    output job_t              enq_job,
    output wr_req_t           wr
);

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] used_reg, used_next;
    logic [ADDR_W-1:0] run_wp_reg, run_wp_next;
    logic [LEN_W-1:0]  run_rem_reg, run_rem_next;
    logic [LEN_W-1:0]  run_len_reg, run_len_next;
    logic              run_ok_reg, run_ok_next;
    logic              burst_pend_reg, burst_pend_next;

    logic              accept;
    logic [ADDR_W-1:0] free_cur;
    logic [ADDR_W-1:0] used_new;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  eff_rem;
    logic [LEN_W-1:0]  rem_dec;
    logic [ADDR_W-1:0] eff_wp;
    logic [ADDR_W-1:0] wp_adv;
    logic              eff_ok;
    logic              run_open;
    logic              refuse;

    function automatic logic [ADDR_W-1:0] free_of(
        input logic [RING_W-1:0] ring,
        input logic [ADDR_W-1:0] used
    );
        logic [RING_W-1:0] tmp;
        tmp = ring - RING_W'(1) - RING_W'(used);
        return ADDR_W'(tmp);
    endfunction

    assign busy   = q_full || burst_pend_reg;
    assign accept = start && !busy;
    assign free_cur = free_of(ring_len, used_reg);

    // Command bounds check
    assign refuse = (length == '0) || (int'(length) > MAX_XFER)
                    || (int'(length) > int'(used_reg));

    // Item decode and state update
    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        used_next       = used_reg;
        run_wp_next     = run_wp_reg;
        run_rem_next    = run_rem_reg;
        run_len_next    = run_len_reg;
        run_ok_next     = run_ok_reg;
        burst_pend_next = burst_pend_reg;
        enq             = 1'b0;
        enq_job         = '0;
        wr              = '0;
        eff_len         = run_len_reg;
        eff_rem         = run_rem_reg;
        eff_ok          = run_ok_reg;
        eff_wp          = run_wp_reg;
        run_open        = 1'b0;
        rem_dec         = '0;
        wp_adv          = '0;
        used_new        = used_reg;

        if (burst_done)
        begin
            burst_pend_next = 1'b0;
        end

        // refused single beat carries the current fill
        enq_job.last     = 1'b1;
        enq_job.accepted = 1'b0;
        enq_job.count    = '0;
        enq_job.used     = USED_W'(used_reg);
        enq_job.free     = USED_W'(free_cur);

        if (cfg_clear)
        begin
            wp_next      = '0;
            rp_next      = '0;
            used_next    = '0;
            run_wp_next  = '0;
            run_rem_next = '0;
            run_len_next = '0;
            run_ok_next  = 1'b0;
        end
        else if (accept)
        begin
            enq = 1'b1;
            unique case (kind_t'(kind))
                KIND_WRITE:
                begin
                    if (first)
                    begin
                        eff_len  = length;
                        eff_rem  = length;
                        eff_ok   = (length != '0) && (int'(length) <= MAX_XFER)
                                   && (int'(length) <= int'(free_cur));
                        eff_wp   = wp_reg;
                        run_open = (length != '0);
                        run_len_next = length;
                        run_rem_next = '0;
                        run_ok_next  = 1'b0;
                        run_wp_next  = wp_reg;
                    end
                    else
                    begin
                        run_open = (run_rem_reg != '0);
                    end

                    if (run_open)
                    begin
                        wp_adv  = ring_add(eff_wp, RING_W'(1), ring_len);
                        rem_dec = eff_rem - LEN_W'(1);
                        if (eff_ok)
                        begin
                            wr.we   = 1'b1;
                            wr.addr = eff_wp;
                            wr.data = data;
                        end
                        run_wp_next  = eff_ok ? wp_adv : eff_wp;
                        run_len_next = eff_len;
                        if (rem_dec != '0)
                        begin
                            // mid-run byte
                            run_rem_next = rem_dec;
                            run_ok_next  = eff_ok;
                            enq_job.last = 1'b0;
                        end
                        else
                        begin
                            // last byte: commit when the run fit
                            run_rem_next = '0;
                            run_ok_next  = 1'b0;
                            if (eff_ok)
                            begin
                                wp_next          = wp_adv;
                                used_new         = used_reg + ADDR_W'(eff_len);
                                used_next        = used_new;
                                enq_job.accepted = 1'b1;
                                enq_job.count    = eff_len;
                                enq_job.used     = USED_W'(used_new);
                                enq_job.free     = USED_W'(free_of(ring_len, used_new));
                            end
                        end
                    end
                end
                KIND_DISCARD:
                begin
                    run_rem_next = '0;
                    run_ok_next  = 1'b0;
                    if (!refuse)
                    begin
                        rp_next          = ring_add(rp_reg, RING_W'(length), ring_len);
                        used_new         = used_reg - ADDR_W'(length);
                        used_next        = used_new;
                        enq_job.accepted = 1'b1;
                        enq_job.count    = length;
                        enq_job.used     = USED_W'(used_new);
                        enq_job.free     = USED_W'(free_of(ring_len, used_new));
                    end
                end
                KIND_READ:
                begin
                    run_rem_next = '0;
                    run_ok_next  = 1'b0;
                    if (!refuse)
                    begin
                        rp_next          = ring_add(rp_reg, RING_W'(length), ring_len);
                        used_new         = used_reg - ADDR_W'(length);
                        used_next        = used_new;
                        burst_pend_next  = 1'b1;
                        enq_job.burst    = 1'b1;
                        enq_job.addr     = rp_reg;
                        enq_job.accepted = 1'b1;
                        enq_job.count    = length;
                        enq_job.used     = USED_W'(used_new);
                        enq_job.free     = USED_W'(free_of(ring_len, used_new));
                    end
                end
                KIND_PEEK:
                begin
                    run_rem_next = '0;
                    run_ok_next  = 1'b0;
                    if (!refuse)
                    begin
                        burst_pend_next  = 1'b1;
                        enq_job.burst    = 1'b1;
                        enq_job.addr     = rp_reg;
                        enq_job.accepted = 1'b1;
                        enq_job.count    = length;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            used_reg       <= '0;
            run_wp_reg     <= '0;
            run_rem_reg    <= '0;
            run_len_reg    <= '0;
            run_ok_reg     <= 1'b0;
            burst_pend_reg <= 1'b0;
        end
        else
        begin
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            used_reg       <= used_next;
            run_wp_reg     <= run_wp_next;
            run_rem_reg    <= run_rem_next;
            run_len_reg    <= run_len_next;
            run_ok_reg     <= run_ok_next;
            burst_pend_reg <= burst_pend_next;
        end
    end

`ifndef SYNTHESIS
    // fill level never exceeds capacity
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        RING_W'(used_reg) < ring_len)
        else $error("used count exceeds ring capacity");
`endif

endmodule

>>> hw/rtl/abrb_queue.sv
// Short job queue between the front end and the back end.
// Depends on abrb_pkg for job_t and the queue depth.
module abrb_queue
    import abrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic enq,
    input  job_t enq_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign head  = q_mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QDEPTH));

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(enq) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem_reg[wr_ptr_reg] <= enq_job;
        end
    end

endmodule

>>> hw/rtl/abrb_back.sv
// Back end: byte store, job execution and the registered result beat.
// Depends on abrb_pkg for job_t, wr_req_t, back_state_t and ring_add.
module abrb_back
    import abrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RING_W-1:0] ring_len,
    input  wr_req_t           wr,
    input  logic              q_empty,
    input  job_t              q_job,
    output logic              pop,
    output logic              burst_done,
    output logic              result_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last,
    output logic              accepted,
    output logic [LEN_W-1:0]  count,
    output logic [USED_W-1:0] used_bytes,
    output logic [USED_W-1:0] free_bytes
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    job_t              meta_reg, meta_next;

    logic              res_valid_reg;
    logic              res_sel_reg;
    logic              res_last_reg;
    logic              res_acc_reg;
    logic [LEN_W-1:0]  res_count_reg;
    logic [USED_W-1:0] res_used_reg;
    logic [USED_W-1:0] res_free_reg;

    logic              beat;
    logic              beat_sel;
    logic              beat_last;
    job_t              beat_job;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && q_job.burst && (q_job.count != LEN_W'(1)))
                begin
                    state_next = BK_BURST;
                end
            end
            BK_BURST:
            begin
                if (rem_reg == LEN_W'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    // Beat issue and burst bookkeeping
    always_comb
    begin
        pop        = 1'b0;
        burst_done = 1'b0;
        beat       = 1'b0;
        beat_sel   = 1'b0;
        beat_last  = 1'b0;
        beat_job   = meta_reg;
        rd_en      = 1'b0;
        rd_addr    = addr_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        meta_next  = meta_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    beat     = 1'b1;
                    beat_job = q_job;
                    beat_sel = q_job.burst;
                    if (q_job.burst)
                    begin
                        beat_last  = (q_job.count == LEN_W'(1));
                        burst_done = beat_last;
                        rd_en      = 1'b1;
                        rd_addr    = q_job.addr;
                        addr_next  = ring_add(q_job.addr, RING_W'(1), ring_len);
                        rem_next   = q_job.count - LEN_W'(1);
                        meta_next  = q_job;
                    end
                    else
                    begin
                        beat_last = q_job.last;
                    end
                end
            end
            BK_BURST:
            begin
                beat       = 1'b1;
                beat_sel   = 1'b1;
                beat_last  = (rem_reg == LEN_W'(1));
                burst_done = beat_last;
                rd_en      = 1'b1;
                rd_addr    = addr_reg;
                addr_next  = ring_add(addr_reg, RING_W'(1), ring_len);
                rem_next   = rem_reg - LEN_W'(1);
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= beat;
        end
    end

    // Burst context and result payload
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        rem_reg       <= rem_next;
        meta_reg      <= meta_next;
        res_sel_reg   <= beat_sel;
        res_last_reg  <= beat_last;
        res_acc_reg   <= beat_job.accepted;
        res_count_reg <= beat_job.count;
        res_used_reg  <= beat_job.used;
        res_free_reg  <= beat_job.free;
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign result_valid = res_valid_reg;
    assign out_byte     = res_sel_reg ? rd_data_reg : '0;
    assign last         = res_last_reg;
    assign accepted     = res_acc_reg;
    assign count        = res_count_reg;
    assign used_bytes   = res_used_reg;
    assign free_bytes   = res_free_reg;

`ifndef SYNTHESIS
    // a refused or mid-run beat carries no byte and no count
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_acc_reg) |-> (res_count_reg == '0 && out_byte == '0))
        else $error("refused beat carries data or count");

    // no queue pop while a burst is running
    a_no_pop_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_BURST) |-> !pop)
        else $error("queue popped during burst");

    // the final burst beat returns the back end to idle
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        burst_done |=> (state_reg == BK_IDLE))
        else $error("back end not idle after burst end");
`endif

endmodule

>>> hw/rtl/atomic_byte_ring_buffer_top.sv
// Top level of the atomic byte ring buffer: APB register, front end, job queue
// and back end with the byte store. Depends on abrb_pkg, abrb_front,
// abrb_queue and abrb_back.

// An item is taken when start is high and busy is low. A write run streams at
// one byte per cycle while busy stays low; each write byte, discard and refused
// command gives one result beat, passed through the job queue and the registered
// result stage. An accepted read or peek of N bytes gives N beats, one per cycle
// from the store's single read port, and holds busy until its last byte is read
// out of the store. Results are shown on result_valid for one cycle and cannot
// be held off. The store needs no clearing pass after reset; only committed
// bytes are ever read. Writing size_in_use empties the ring.
module atomic_byte_ring_buffer_top
    import abrb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [LEN_W-1:0]      length,
    input  logic                  first,
    input  logic [BYTE_W-1:0]     data,
    // result channel
    output logic                  result_valid,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  last,
    output logic                  accepted,
    output logic [LEN_W-1:0]      count,
    output logic [USED_W-1:0]     used_bytes,
    output logic [USED_W-1:0]     free_bytes
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [RING_W-1:0] ring_reg, ring_next;
    logic              cfg_wr;
    logic              cfg_clear;

    logic              enq;
    job_t              enq_job;
    job_t              q_head;
    logic              q_empty;
    logic              q_full;
    logic              pop;
    logic              burst_done;
    wr_req_t           wr;

    // Register write decode
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_clear = cfg_wr && (paddr[2] == REG_SIZE_IN_USE);

    // Clamp the ring length to the range 2 to DEPTH bytes
    always_comb
    begin
        size_next = size_reg;
        ring_next = ring_reg;
        if (cfg_clear)
        begin
            size_next = pwdata[SIZE_W-1:0];
            priority if (int'(pwdata[SIZE_W-1:0]) < 2)
            begin
                ring_next = RING_W'(2);
            end
            else if (int'(pwdata[SIZE_W-1:0]) > DEPTH)
            begin
                ring_next = RING_W'(DEPTH);
            end
            else
            begin
                ring_next = RING_W'(pwdata[SIZE_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            ring_reg <= RING_W'(DEPTH);
        end
        else
        begin
            size_reg <= size_next;
            ring_reg <= ring_next;
        end
    end

    // Register read
    assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? CFG_DATA_W'(size_reg) : '0;

    abrb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_clear  (cfg_clear),
        .ring_len   (ring_reg),
        .start      (start),
        .kind       (kind),
        .length     (length),
        .first      (first),
        .data       (data),
        .q_full     (q_full),
        .burst_done (burst_done),
        .busy       (busy),
        .enq        (enq),
        .enq_job    (enq_job),
        .wr         (wr)
    );

    abrb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_job (enq_job),
        .pop     (pop),
        .head    (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    abrb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ring_len     (ring_reg),
        .wr           (wr),
        .q_empty      (q_empty),
        .q_job        (q_head),
        .pop          (pop),
        .burst_done   (burst_done),
        .result_valid (result_valid),
        .out_byte     (out_byte),
        .last         (last),
        .accepted     (accepted),
        .count        (count),
        .used_bytes   (used_bytes),
        .free_bytes   (free_bytes)
    );

endmodule

>>> tb/sv/atomic_byte_ring_buffer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for atomic_byte_ring_buffer_top: directed table, then random phases.
// Each phase uses its own ring size. Depends on abrb_pkg and the block's RTL only.

module atomic_byte_ring_buffer_top_test;
    import abrb_pkg::*;

    // One result beat as seen on the result ports
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              accepted;
        logic [LEN_W-1:0]  count;
        logic [USED_W-1:0] used;
        logic [USED_W-1:0] free;
    } beat_t;

    // One directed stimulus row; want is only meaningful where typed is set
    typedef struct packed {
        kind_t             op;
        logic [LEN_W-1:0]  len;
        logic              first;
        logic [BYTE_W-1:0] data;
        logic              typed;
        beat_t             want;
    } row_t;

    localparam beat_t REFUSED_EMPTY = '{8'h00, 1'b1, 1'b0, 7'd0, 10'd0, 10'd1023};
    localparam beat_t OPEN_EMPTY    = '{8'h00, 1'b0, 1'b0, 7'd0, 10'd0, 10'd1023};
    localparam beat_t NO_BEAT       = '0;

    // Directed part at the reset ring size of 1024 bytes
    localparam row_t DIRECTED [24] = '{
        // commands and a lone byte on an empty ring
        '{KIND_READ,    7'd1,   1'b0, 8'h00, 1'b1, REFUSED_EMPTY},
        '{KIND_PEEK,    7'd0,   1'b0, 8'h00, 1'b1, REFUSED_EMPTY},
        '{KIND_DISCARD, 7'd127, 1'b0, 8'h00, 1'b1, REFUSED_EMPTY},
        '{KIND_WRITE,   7'd5,   1'b0, 8'hFF, 1'b1, REFUSED_EMPTY},
        // zero-length run ends at once
        '{KIND_WRITE,   7'd0,   1'b1, 8'h11, 1'b1, REFUSED_EMPTY},
        // three-byte run, committed on its last byte
        '{KIND_WRITE,   7'd3,   1'b1, 8'h00, 1'b1, OPEN_EMPTY},
        '{KIND_WRITE,   7'd0,   1'b0, 8'hFF, 1'b1, OPEN_EMPTY},
        '{KIND_WRITE,   7'd0,   1'b0, 8'hA5, 1'b1,
          '{8'h00, 1'b1, 1'b1, 7'd3, 10'd3, 10'd1020}},
        '{KIND_PEEK,    7'd3,   1'b0, 8'h00, 1'b0, NO_BEAT},
        '{KIND_READ,    7'd2,   1'b0, 8'h00, 1'b0, NO_BEAT},
        '{KIND_DISCARD, 7'd1,   1'b0, 8'h00, 1'b1,
          '{8'h00, 1'b1, 1'b1, 7'd1, 10'd0, 10'd1023}},
        // oversized run, cut by a new run, which a read cuts in turn
        '{KIND_WRITE,   7'd65,  1'b1, 8'h77, 1'b1, OPEN_EMPTY},
        '{KIND_WRITE,   7'd2,   1'b1, 8'h5A, 1'b1, OPEN_EMPTY},
        '{KIND_READ,    7'd1,   1'b0, 8'h00, 1'b1, REFUSED_EMPTY},
        '{KIND_WRITE,   7'd0,   1'b0, 8'h12, 1'b1, REFUSED_EMPTY},
        '{KIND_WRITE,   7'd64,  1'b1, 8'hC3, 1'b1, OPEN_EMPTY},
        '{KIND_DISCARD, 7'd64,  1'b0, 8'h00, 1'b1, REFUSED_EMPTY},
        // single-byte run, then too little data for the maximum request
        '{KIND_WRITE,   7'd1,   1'b1, 8'h3C, 1'b1,
          '{8'h00, 1'b1, 1'b1, 7'd1, 10'd1, 10'd1022}},
        '{KIND_READ,    7'd64,  1'b0, 8'h00, 1'b1,
          '{8'h00, 1'b1, 1'b0, 7'd0, 10'd1, 10'd1022}},
        '{KIND_PEEK,    7'd1,   1'b0, 8'h00, 1'b0, NO_BEAT},
        '{KIND_WRITE,   7'd2,   1'b1, 8'h81, 1'b1,
          '{8'h00, 1'b0, 1'b0, 7'd0, 10'd1, 10'd1022}},
        '{KIND_WRITE,   7'd0,   1'b0, 8'h7E, 1'b1,
          '{8'h00, 1'b1, 1'b1, 7'd2, 10'd3, 10'd1020}},
        '{KIND_READ,    7'd3,   1'b0, 8'h00, 1'b0, NO_BEAT},
        '{KIND_PEEK,    7'd64,  1'b0, 8'h00, 1'b1, REFUSED_EMPTY}
    };

    // Ring sizes of the random phases, out-of-range values among them
    localparam logic [SIZE_W-1:0] RING_SIZES [9] = '{
        11'd2, 11'd0, 11'd2047, 11'd7, 11'd33, 11'd100, 11'd1024, 11'd1025, 11'd3
    };
    localparam int PHASE_ITEMS = 22;
    localparam int SETTLE_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    kind_t                 kind;
    logic [LEN_W-1:0]      length;
    logic                  first;
    logic [BYTE_W-1:0]     data;
    logic                  result_valid;
    logic [BYTE_W-1:0]     out_byte;
    logic                  last;
    logic                  accepted;
    logic [LEN_W-1:0]      count;
    logic [USED_W-1:0]     used_bytes;
    logic [USED_W-1:0]     free_bytes;

    atomic_byte_ring_buffer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .length       (length),
        .first        (first),
        .data         (data),
        .result_valid (result_valid),
        .out_byte     (out_byte),
        .last         (last),
        .accepted     (accepted),
        .count        (count),
        .used_bytes   (used_bytes),
        .free_bytes   (free_bytes)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow ring state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [SIZE_W-1:0] ring_size_reg;
    int unsigned       wr_pos;
    int unsigned       rd_pos;
    int unsigned       run_pos;
    int unsigned       run_left;
    int unsigned       run_len;
    bit                run_good;

    beat_t       beats_due [$];
    int unsigned mismatches;
    int unsigned items_sent;
    int          burst_left;
    int          gap_max;

    function automatic int unsigned ring_len();
        if (ring_size_reg < 2)
        begin
            return 2;
        end
        if (ring_size_reg > DEPTH)
        begin
            return DEPTH;
        end
        return ring_size_reg;
    endfunction

    function automatic int unsigned bytes_used();
        int unsigned s;
        int unsigned w;
        int unsigned r;
        s = ring_len();
        w = wr_pos % s;
        r = rd_pos % s;
        return (r <= w) ? (w - r) : (s + w - r);
    endfunction

    function automatic int unsigned bytes_free();
        return ring_len() - 1 - bytes_used();
    endfunction

    // Queue one beat; occupancy is taken after the step's state change
    function automatic void add_beat(int unsigned b, bit l, bit a, int unsigned c);
        beat_t nb;
        nb.out_byte = BYTE_W'(b);
        nb.last     = l;
        nb.accepted = a;
        nb.count    = LEN_W'(c);
        nb.used     = USED_W'(bytes_used());
        nb.free     = USED_W'(bytes_free());
        beats_due.push_back(nb);
    endfunction

    // Size register write empties the ring and drops any open run
    function automatic void ring_configure(logic [SIZE_W-1:0] value);
        ring_size_reg = value;
        wr_pos   = 0;
        rd_pos   = 0;
        run_pos  = 0;
        run_left = 0;
        run_len  = 0;
        run_good = 0;
    endfunction

    // Work out the beats caused by one accepted item
    function automatic void ring_step(kind_t k, int unsigned n, bit f, logic [BYTE_W-1:0] d);
        int unsigned       s;
        int unsigned       r;
        bit                ok;
        logic [BYTE_W-1:0] grab [MAX_XFER];
        s = ring_len();
        if (k == KIND_WRITE)
        begin
            if (f)
            begin
                run_len  = n;
                run_left = n;
                run_good = (n >= 1 && n <= MAX_XFER && n <= bytes_free());
                run_pos  = wr_pos % s;
                if (n == 0)
                begin
                    add_beat(0, 1'b1, 1'b0, 0);
                    return;
                end
            end
            else if (run_left == 0)
            begin
                // lone byte with no open run
                add_beat(0, 1'b1, 1'b0, 0);
                return;
            end
            if (run_good)
            begin
                ring_mem[run_pos % s] = d;
                run_pos = (run_pos + 1) % s;
            end
            run_left--;
            if (run_left != 0)
            begin
                add_beat(0, 1'b0, 1'b0, 0);
                return;
            end
            if (run_good)
            begin
                wr_pos = run_pos;
            end
            ok = run_good;
            run_good = 0;
            add_beat(0, 1'b1, ok, ok ? run_len : 0);
            return;
        end

        // any command drops an open run
        run_left = 0;
        run_good = 0;
        if (n == 0 || n > MAX_XFER || n > bytes_used())
        begin
            add_beat(0, 1'b1, 1'b0, 0);
            return;
        end
        if (k == KIND_DISCARD)
        begin
            rd_pos = (rd_pos % s + n) % s;
            add_beat(0, 1'b1, 1'b1, n);
            return;
        end
        r = rd_pos % s;
        for (int unsigned i = 0; i < n; i++)
        begin
            grab[i] = ring_mem[(r + i) % s];
        end
        if (k == KIND_READ)
        begin
            rd_pos = (r + n) % s;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            add_beat(grab[i], (i + 1 == n), 1'b1, n);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Result checker: every beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        beat_t want;
        if (rst_n && result_valid)
        begin
            if (beats_due.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                want = beats_due.pop_front();
                check_field("out_byte", out_byte, want.out_byte);
                check_field("last", last, want.last);
                check_field("accepted", accepted, want.accepted);
                check_field("count", count, want.count);
                check_field("used_bytes", used_bytes, want.used);
                check_field("free_bytes", free_bytes, want.free);
            end
        end
    end

    // Present one item at a falling edge, with bursts and gaps, and wait for it to be taken
    task automatic send_item(input kind_t k, input int unsigned n, input bit f,
                             input logic [BYTE_W-1:0] d);
        @(negedge clk);
        if (gap_max != 0 && burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        start  <= 1'b1;
        kind   <= k;
        length <= LEN_W'(n);
        first  <= f;
        data   <= d;
        burst_left--;
        do @(posedge clk); while (busy);
        items_sent++;
        ring_step(k, n, f, d);
    endtask

    // Write run of n bytes of which only the first sent are issued
    task automatic send_write_run(input int unsigned n, input int unsigned sent);
        send_item(KIND_WRITE, n, 1'b1, BYTE_W'($urandom_range(0, 255)));
        for (int unsigned i = 1; i < sent; i++)
        begin
            send_item(KIND_WRITE, $urandom_range(0, 127), 1'b0, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Stop sending and let every expected beat arrive
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Size register write, then read back
    task automatic set_ring_size(input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_SIZE_IN_USE));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        ring_configure(value[SIZE_W-1:0]);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== CFG_DATA_W'(ring_size_reg))
        begin
            report_mismatch($sformatf("size_in_use read %0d expected %0d", prdata, ring_size_reg));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random operation: mostly clean runs and sized commands, some noise
    task automatic random_op();
        int unsigned pick;
        int unsigned n;
        int unsigned room;
        int unsigned held;
        room = bytes_free();
        held = bytes_used();
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            // complete run, usually short and usually fitting
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, MAX_XFER);
            end
            else
            begin
                n = $urandom_range(1, (room == 0) ? 1 : ((room < 8) ? room : 8));
            end
            send_write_run(n, n);
        end
        else if (pick < 55)
        begin
            // run cut short by whatever follows
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_XFER + 1, 127)
                                             : $urandom_range(2, 12);
            send_write_run(n, $urandom_range(1, (n > 12) ? 4 : n - 1));
        end
        else if (pick < 60)
        begin
            send_item(KIND_WRITE, $urandom_range(0, 127), 1'b0, BYTE_W'($urandom_range(0, 255)));
        end
        else if (pick < 63)
        begin
            send_item(KIND_WRITE, 0, 1'b1, BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            if (held > 0 && $urandom_range(0, 3) != 0)
            begin
                n = $urandom_range(1, (held < MAX_XFER) ? held : MAX_XFER);
            end
            else
            begin
                n = $urandom_range(0, 127);
            end
            send_item(kind_t'($urandom_range(1, 3)), n, 1'($urandom_range(0, 1)),
                      BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence
    initial
    begin : stimulus
        row_t        row;
        int unsigned phase_end;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        kind       = KIND_WRITE;
        length     = '0;
        first      = 1'b0;
        data       = '0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        gap_max    = 3;
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_mem[i] = '0;
        end
        ring_configure(SIZE_RESET);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; a typed row stands in for the computed beat
        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            send_item(row.op, row.len, row.first, row.data);
            if (row.typed)
            begin
                void'(beats_due.pop_back());
                beats_due.push_back(row.want);
            end
        end
        settle();

        // random phases, one ring size each
        foreach (RING_SIZES[p])
        begin
            set_ring_size({21'($urandom), RING_SIZES[p]});
            gap_max = (p % 3 == 2) ? 0 : $urandom_range(1, 6);
            if (p == 1)
            begin
                // oversized run, of which MAX_XFER + 1 bytes are sent, never commits
                send_write_run(MAX_XFER + 1 + $urandom_range(0, 3), MAX_XFER + 1);
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                random_op();
            end
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("atomic_byte_ring_buffer_top test passed");
        end
        else
        begin
            $display("atomic_byte_ring_buffer_top test failed");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("atomic_byte_ring_buffer_top test failed");
        $finish;
    end

endmodule
